// ----- hdl/sic_pkg.sv -----
// shared types, constants and fixed-point helpers for the solar incidence cosine block
`default_nettype none
package sic_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES = 24;

	// angle word before range reduction, angle word inside the cell row, trig value word
	localparam int AW = 36;
	localparam int ZW = 34;
	localparam int TW = 32;
	localparam int SW = 35;

	typedef logic signed [AW-1:0] angle_t;
	typedef logic signed [ZW-1:0] zang_t;
	typedef logic signed [TW-1:0] trig_t;
	typedef logic signed [SW-1:0] sum_t;

	localparam angle_t PI_Q30 = 36'sd3373259426;
	localparam angle_t HALF_PI_Q30 = 36'sd1686629713;
	localparam angle_t TWO_PI_Q30 = 36'sd6746518852;
	localparam trig_t GAIN_Q30 = 32'sd652032874;
	localparam trig_t DECL_AMP_Q30 = 32'sd439461054;

	localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
		32'd67021686, 32'd33543515, 32'd16775850, 32'd8388437,
		32'd4194282, 32'd2097149, 32'd1048575, 32'd524287,
		32'd262143, 32'd131071, 32'd65535, 32'd32767,
		32'd16383, 32'd8191, 32'd4095, 32'd2047,
		32'd1023, 32'd511, 32'd255, 32'd127
	};

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 16;
	localparam logic [CFG_IW-1:0] REG_LATITUDE = 2'd0;
	localparam logic [CFG_IW-1:0] REG_SLOPE = 2'd1;
	localparam logic [CFG_IW-1:0] REG_AZIMUTH = 2'd2;

	// q.30 product, rounded half up
	function automatic trig_t qmul(input trig_t a, input trig_t b);
		logic signed [63:0] p;
		p = a * b;
		p = p + 64'sd536870912;
		return trig_t'(p >>> 30);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/sic_front.sv -----
// hour angle and day angle conversion pipeline
`default_nettype none
module sic_front import sic_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic signed [16:0]  solar_hour,
	input  logic [8:0]          year_day,
	output angle_t              hour_angle,
	output angle_t              day_angle
);

	localparam logic [17:0] HOUR_BIAS = 18'd98304;
	localparam logic [17:0] DAY1 = 18'd49152;
	localparam logic [17:0] DAY2 = 18'd98304;
	localparam logic [17:0] DAY3 = 18'd147456;
	localparam logic [16:0] NOON = 17'd24576;
	localparam logic [9:0] DAY_OFFSET = 10'd284;
	localparam logic [9:0] YEAR1 = 10'd365;
	localparam logic [9:0] YEAR2 = 10'd730;
	localparam logic [15:0] DIV3_RECIP = 16'd43691;
	localparam logic [31:0] PI_U = 32'd3373259426;
	localparam logic [45:0] PI_THIRD = 46'd1124419808;
	localparam logic [45:0] PI_TWO_THIRD = 46'd2248839617;
	localparam logic [24:0] STEP_Q = 25'd18483613;
	localparam logic [6:0] STEP_R = 7'd107;
	localparam logic [15:0] HALF_YEAR = 16'd182;
	localparam logic [23:0] DIV365_RECIP = 24'd11767034;

	logic [17:0]        hb;
	logic [17:0]        hmod;
	logic [9:0]         ds;
	logic [9:0]         dmod;
	logic signed [16:0] dh_s1;
	logic [8:0]         n_s1;

	always_comb begin
		hb = {solar_hour[16], solar_hour} + HOUR_BIAS;
		priority if (hb >= DAY3) hmod = hb - DAY3;
		else if (hb >= DAY2) hmod = hb - DAY2;
		else if (hb >= DAY1) hmod = hb - DAY1;
		else hmod = hb;
		ds = {1'b0, year_day} + DAY_OFFSET;
		priority if (ds >= YEAR2) dmod = ds - YEAR2;
		else if (ds >= YEAR1) dmod = ds - YEAR1;
		else dmod = ds;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dh_s1 <= $signed(hmod[16:0] - NOON);
			n_s1 <= dmod[8:0];
		end
	end

	// hour: |dh| = 3a + b, so |dh|*pi/24576 = (a*pi + floor(b*pi/3)) >> 13
	logic [14:0] habs;
	logic [30:0] aprod;
	logic [14:0] habs_s2;
	logic [13:0] a_s2;
	logic        neg_s2;
	logic [33:0] nq_s2;
	logic [15:0] rv_s2;

	always_comb begin
		habs = dh_s1[16] ? 15'(-dh_s1) : dh_s1[14:0];
		aprod = habs * DIV3_RECIP;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			habs_s2 <= habs;
			a_s2 <= aprod[30:17];
			neg_s2 <= dh_s1[16];
			nq_s2 <= n_s1 * STEP_Q;
			rv_s2 <= {7'd0, n_s1} * {9'd0, STEP_R} + HALF_YEAR;
		end
	end

	logic [14:0] brem;
	logic [45:0] pcorr;
	logic [39:0] qprod;
	logic [45:0] p_s3;
	logic        neg_s3;
	logic [33:0] nq_s3;
	logic [7:0]  qd_s3;

	always_comb begin
		brem = habs_s2 - 15'(3 * a_s2);
		unique case (brem[1:0])
			2'd1:    pcorr = PI_THIRD;
			2'd2:    pcorr = PI_TWO_THIRD;
			default: pcorr = '0;
		endcase
		qprod = rv_s2 * DIV365_RECIP;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= a_s2 * PI_U + pcorr;
			neg_s3 <= neg_s2;
			nq_s3 <= nq_s2;
			qd_s3 <= qprod[39:32];
		end
	end

	logic [32:0] mag;
	angle_t      hr_s4;
	angle_t      yr_s4;

	assign mag = p_s3[45:13];

	always_ff @(posedge clk) begin
		if (en) begin
			// morning is positive
			hr_s4 <= neg_s3 ? $signed({3'd0, mag}) : -$signed({3'd0, mag});
			yr_s4 <= $signed({2'd0, nq_s3 + {26'd0, qd_s3}});
		end
	end

	assign hour_angle = hr_s4;
	assign day_angle = yr_s4;

endmodule
`default_nettype wire

// ----- hdl/sic_cordic_cell.sv -----
// one rotation step of the cordic row
`default_nettype none
module sic_cordic_cell import sic_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  en,
	input  trig_t prev_x,
	input  trig_t prev_y,
	input  zang_t prev_z,
	input  logic  prev_flip,
	output trig_t x,
	output trig_t y,
	output zang_t z,
	output logic  flip
);

	localparam zang_t ATAN_STEP = $signed({2'd0, ATAN_Q30[IDX]});

	trig_t x_q, y_q;
	zang_t z_q;
	logic  flip_q;
	trig_t dx, dy;

	assign dx = prev_y >>> IDX;
	assign dy = prev_x >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!prev_z[ZW-1]) begin
				x_q <= prev_x - dx;
				y_q <= prev_y + dy;
				z_q <= prev_z - ATAN_STEP;
			end else begin
				x_q <= prev_x + dx;
				y_q <= prev_y - dy;
				z_q <= prev_z + ATAN_STEP;
			end
			flip_q <= prev_flip;
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;
	assign flip = flip_q;

endmodule
`default_nettype wire

// ----- hdl/sic_cordic_chain.sv -----
// range reduction, row of cordic cells and sign restore
`default_nettype none
module sic_cordic_chain import sic_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic   clk,
	input  logic   en,
	input  angle_t angle,
	output trig_t  cosine,
	output trig_t  sine
);

	angle_t r1, r2;
	logic   flp;
	zang_t  z_q;
	logic   flip_q;

	always_comb begin
		priority if (angle > PI_Q30) r1 = angle - TWO_PI_Q30;
		else if (angle < -PI_Q30) r1 = angle + TWO_PI_Q30;
		else r1 = angle;
		// fold into the right half plane, which negates both outputs
		priority if (r1 > HALF_PI_Q30) begin
			r2 = r1 - PI_Q30;
			flp = 1'b1;
		end else if (r1 < -HALF_PI_Q30) begin
			r2 = r1 + PI_Q30;
			flp = 1'b1;
		end else begin
			r2 = r1;
			flp = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_q <= r2[ZW-1:0];
			flip_q <= flp;
		end
	end

	trig_t x_c [STAGES+1];
	trig_t y_c [STAGES+1];
	zang_t z_c [STAGES+1];
	logic  f_c [STAGES+1];

	assign x_c[0] = GAIN_Q30;
	assign y_c[0] = '0;
	assign z_c[0] = z_q;
	assign f_c[0] = flip_q;

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		sic_cordic_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.en        (en),
			.prev_x    (x_c[i]),
			.prev_y    (y_c[i]),
			.prev_z    (z_c[i]),
			.prev_flip (f_c[i]),
			.x         (x_c[i+1]),
			.y         (y_c[i+1]),
			.z         (z_c[i+1]),
			.flip      (f_c[i+1])
		);
	end

	trig_t cos_q, sin_q;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= f_c[STAGES] ? -x_c[STAGES] : x_c[STAGES];
			sin_q <= f_c[STAGES] ? -y_c[STAGES] : y_c[STAGES];
		end
	end

	assign cosine = cos_q;
	assign sine = sin_q;

endmodule
`default_nettype wire

// ----- hdl/sic_terms.sv -----
// five-term product sum, one rounded multiply per factor level
`default_nettype none
module sic_terms import sic_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  trig_t sd,
	input  trig_t cd,
	input  trig_t sl,
	input  trig_t cl,
	input  trig_t ss,
	input  trig_t cs,
	input  trig_t sa,
	input  trig_t ca,
	input  trig_t sh,
	input  trig_t ch,
	output sum_t  sum
);

	trig_t a_s1, b_s1, c_s1, d_s1, e_s1, cs_s1, ss_s1, sa_s1, ca_s1, ch_s1, sh_s1;
	trig_t t1_s2, b_s2, c_s2, d_s2, e_s2, ca_s2, ch_s2, sh_s2;
	trig_t t1_s3, t2_s3, t3_s3, d_s3, t5_s3, ch_s3;
	trig_t t1_s4, t2_s4, t3_s4, t4_s4, t5_s4;
	sum_t  sum_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= qmul(sd, sl);
			b_s1 <= qmul(sd, cl);
			c_s1 <= qmul(cd, cl);
			d_s1 <= qmul(cd, sl);
			e_s1 <= qmul(cd, ss);
			cs_s1 <= cs;
			ss_s1 <= ss;
			sa_s1 <= sa;
			ca_s1 <= ca;
			ch_s1 <= ch;
			sh_s1 <= sh;

			t1_s2 <= qmul(a_s1, cs_s1);
			b_s2 <= qmul(b_s1, ss_s1);
			c_s2 <= qmul(c_s1, cs_s1);
			d_s2 <= qmul(d_s1, ss_s1);
			e_s2 <= qmul(e_s1, sa_s1);
			ca_s2 <= ca_s1;
			ch_s2 <= ch_s1;
			sh_s2 <= sh_s1;

			t1_s3 <= t1_s2;
			t2_s3 <= qmul(b_s2, ca_s2);
			t3_s3 <= qmul(c_s2, ch_s2);
			d_s3 <= qmul(d_s2, ca_s2);
			t5_s3 <= qmul(e_s2, sh_s2);
			ch_s3 <= ch_s2;

			t1_s4 <= t1_s3;
			t2_s4 <= t2_s3;
			t3_s4 <= t3_s3;
			t4_s4 <= qmul(d_s3, ch_s3);
			t5_s4 <= t5_s3;

			sum_s5 <= SW'(t1_s4) - SW'(t2_s4) + SW'(t3_s4) + SW'(t4_s4) + SW'(t5_s4);
		end
	end

	assign sum = sum_s5;

endmodule
`default_nettype wire

// ----- hdl/solar_incidence_cosine_top.sv -----
// top level of the solar incidence cosine block
`default_nettype none
// Cosine of the solar incidence angle on a tilted surface, Q1.15, clamped to
// zero when the sun is behind the surface. Fully pipelined: one transaction
// per cycle while not stalled, through two cordic cell rows in series (day
// angle, then declination together with latitude, slope, azimuth and hour
// angle). The pipeline only holds when its last stage is full and the output
// register is stalled. Configuration is to be written only while the block is
// idle; the block does not enforce this, and cfg_ready is always high.
module solar_incidence_cosine_top import sic_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [16:0] solar_hour,
	input  logic [8:0]         year_day,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [15:0]        incidence_cosine,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_IW-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]  cfg_data
);

	localparam int DEPTH = 2 * CORDIC_STAGES + 14;
	localparam int HR_DLY = CORDIC_STAGES + 3;

	logic signed [14:0] lat_q;
	logic [14:0]        slope_q;
	logic signed [15:0] az_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q <= '0;
			slope_q <= '0;
			az_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LATITUDE: lat_q <= cfg_data[14:0];
				REG_SLOPE:    slope_q <= cfg_data[14:0];
				REG_AZIMUTH:  az_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	logic             en;
	logic [DEPTH-1:0] vld_q;
	logic             res_valid_q;
	logic [15:0]      res_q;

	assign en = !vld_q[DEPTH-1] || !res_valid_q || !result_stall;
	assign item_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], item_valid};
		end
	end

	angle_t hour_angle, day_angle;

	sic_front u_front (
		.clk        (clk),
		.en         (en),
		.solar_hour (solar_hour),
		.year_day   (year_day),
		.hour_angle (hour_angle),
		.day_angle  (day_angle)
	);

	trig_t day_sin;

	sic_cordic_chain #(.STAGES(CORDIC_STAGES)) u_day (
		.clk    (clk),
		.en     (en),
		.angle  (day_angle),
		.cosine (),
		.sine   (day_sin)
	);

	angle_t decl_q;
	angle_t hr_dly_q [HR_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			decl_q <= AW'(qmul(DECL_AMP_Q30, day_sin));
			hr_dly_q[0] <= hour_angle;
			for (int i = 1; i < HR_DLY; i++) begin
				hr_dly_q[i] <= hr_dly_q[i-1];
			end
		end
	end

	angle_t lat_ang, slope_ang, az_ang;

	assign lat_ang = {{(AW-32){lat_q[14]}}, lat_q, 17'd0};
	assign slope_ang = {{(AW-32){1'b0}}, slope_q, 17'd0};
	assign az_ang = {{(AW-33){az_q[15]}}, az_q, 17'd0};

	trig_t sd, cd, sl, cl, ss, cs, sa, ca, sh, ch;

	sic_cordic_chain #(.STAGES(CORDIC_STAGES)) u_decl (
		.clk (clk), .en (en), .angle (decl_q), .cosine (cd), .sine (sd)
	);
	sic_cordic_chain #(.STAGES(CORDIC_STAGES)) u_lat (
		.clk (clk), .en (en), .angle (lat_ang), .cosine (cl), .sine (sl)
	);
	sic_cordic_chain #(.STAGES(CORDIC_STAGES)) u_slope (
		.clk (clk), .en (en), .angle (slope_ang), .cosine (cs), .sine (ss)
	);
	sic_cordic_chain #(.STAGES(CORDIC_STAGES)) u_az (
		.clk (clk), .en (en), .angle (az_ang), .cosine (ca), .sine (sa)
	);
	sic_cordic_chain #(.STAGES(CORDIC_STAGES)) u_hour (
		.clk (clk), .en (en), .angle (hr_dly_q[HR_DLY-1]), .cosine (ch), .sine (sh)
	);

	sum_t sum;

	sic_terms u_terms (
		.clk (clk), .en (en),
		.sd (sd), .cd (cd), .sl (sl), .cl (cl), .ss (ss),
		.cs (cs), .sa (sa), .ca (ca), .sh (sh), .ch (ch),
		.sum (sum)
	);

	sum_t        rnd;
	logic [15:0] q_next;

	always_comb begin
		rnd = sum + SW'(16384);
		if (sum < 0) q_next = '0;
		else if ((rnd >>> 15) > SW'(32768)) q_next = 16'h8000;
		else q_next = rnd[30:15];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en && vld_q[DEPTH-1]) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_q[DEPTH-1]) begin
			res_q <= q_next;
		end
	end

	assign result_valid = res_valid_q;
	assign incidence_cosine = res_q;

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> incidence_cosine <= 16'h8000)
		else $error("incidence cosine above one");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall && vld_q[DEPTH-1]))
		else $error("input stalled without a full pipeline");

	a_last_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[DEPTH-1]) |=> result_valid)
		else $error("last stage transaction lost");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench for the solar incidence cosine block
`default_nettype none
module testbench;
	import sic_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSTAGES = CORDIC_STAGES_DEF;
	localparam int PIPE_DEPTH = 2 * NSTAGES + 15;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 400;
	localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;
	localparam logic signed [16:0] HOUR_NOON = 17'sd24576;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic signed [16:0] solar_hour = '0;
	logic [8:0] year_day = 9'd1;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [15:0] incidence_cosine;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	solar_incidence_cosine_top dut (.*);

	always #10 clk = ~clk;

	// configuration copy held by the predictor
	logic [14:0] lat_reg, slope_reg;
	logic [15:0] azim_reg;

	logic [15:0] cosine_q[$];
	int errors = 0;
	int checked = 0;
	int idle_cnt = 0;
	int rx_wait = 0;
	int rx_hold = 0;
	bit no_gaps = 0;

	typedef struct {
		logic signed [16:0] hour;
		logic [8:0] day;
		bit known;
		logic [15:0] cosine;
	} stim_row_t;

	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic void rot_trig(input longint ang, output longint c, output longint s);
		bit flip;
		longint x, y, z, dx, dy;
		flip = 0;
		x = longint'(GAIN_Q30);
		y = 0;
		if (ang > longint'(PI_Q30)) ang -= longint'(TWO_PI_Q30);
		else if (ang < -longint'(PI_Q30)) ang += longint'(TWO_PI_Q30);
		if (ang > longint'(HALF_PI_Q30)) begin
			ang -= longint'(PI_Q30);
			flip = 1;
		end else if (ang < -longint'(HALF_PI_Q30)) begin
			ang += longint'(PI_Q30);
			flip = 1;
		end
		z = ang;
		for (int i = 0; i < NSTAGES && i < ATAN_ENTRIES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic [15:0] incidence(input logic signed [16:0] hour, input logic [8:0] day);
		longint dh, hang, dang, decl, junk, q, sum;
		longint cd, sd, cl, sl, cs, ss, ca, sa, ch, sh;
		dh = longint'(hour) - 24576;
		dh = ((dh + 24576 + 3 * 49152) % 49152) - 24576;
		hang = -((dh * longint'(PI_Q30)) / 24576);
		dang = (longint'((284 + int'(day)) % 365) * longint'(TWO_PI_Q30) + 182) / 365;
		rot_trig(dang, junk, sd);
		decl = fx_mul(longint'(DECL_AMP_Q30), sd);
		rot_trig(decl, cd, sd);
		rot_trig(longint'($signed(lat_reg)) * 131072, cl, sl);
		rot_trig(longint'({1'b0, slope_reg}) * 131072, cs, ss);
		rot_trig(longint'($signed(azim_reg)) * 131072, ca, sa);
		rot_trig(hang, ch, sh);
		sum = fx_mul(fx_mul(sd, sl), cs)
			- fx_mul(fx_mul(fx_mul(sd, cl), ss), ca)
			+ fx_mul(fx_mul(fx_mul(cd, cl), cs), ch)
			+ fx_mul(fx_mul(fx_mul(fx_mul(cd, sl), ss), ca), ch)
			+ fx_mul(fx_mul(fx_mul(cd, ss), sa), sh);
		if (sum < 0) sum = 0;
		q = (sum + (64'sd1 <<< 14)) >>> 15;
		if (q > 32768) q = 32768;
		return q[15:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// result side: stall pattern at the falling edge
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			result_stall <= 1'b1;
			rx_hold--;
		end else if (rx_wait > 0) begin
			result_stall <= 1'b1;
			rx_wait--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// result checking and watchdog at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (result_valid && !result_stall) begin
				if (cosine_q.size() == 0)
					report_mismatch("unexpected transaction", incidence_cosine, 16'd0);
				else begin
					logic [15:0] want;
					want = cosine_q.pop_front();
					checked++;
					if (incidence_cosine !== want)
						report_mismatch("incidence_cosine", incidence_cosine, want);
				end
				rx_wait = no_gaps ? 0 : $urandom_range(0, 19);
			end
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cnt);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LATITUDE: lat_reg = val[14:0];
			REG_SLOPE: slope_reg = val[14:0];
			REG_AZIMUTH: azim_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_sample(input logic signed [16:0] hour, input logic [8:0] day,
			input bit known, input logic [15:0] cosine);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		repeat (gap) begin
			@(negedge clk);
			item_valid = 1'b0;
		end
		@(negedge clk);
		item_valid = 1'b1;
		solar_hour = hour;
		year_day = day;
		do @(posedge clk); while (item_stall);
		cosine_q.push_back(known ? cosine : incidence(hour, day));
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid = 1'b0;
		wait (cosine_q.size() == 0);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		logic signed [16:0] h;
		logic [8:0] d;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: h = 17'($urandom);
				1: h = 17'($urandom_range(0, 4096) - 2048);
				default: h = 17'($urandom_range(0, 51200 + 2048) - 2048);
			endcase
			d = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 365));
			send_sample(h, d, 0, '0);
		end
		no_gaps = 0;
	endtask

	stim_row_t rows[] = '{
		// at reset the sum reduces to cos(decl)*cos(hour angle): negative at night
		'{17'sd0, 9'd1, 1, 16'd0},
		'{17'sd0, 9'd172, 1, 16'd0},
		'{17'sd0, 9'd365, 1, 16'd0},
		'{17'sd49152, 9'd80, 1, 16'd0},
		'{-17'sd2048, 9'd200, 1, 16'd0},
		'{HOUR_NOON, 9'd1, 0, 16'd0},
		'{HOUR_NOON, 9'd81, 0, 16'd0},
		'{HOUR_NOON, 9'd172, 0, 16'd0},
		'{HOUR_NOON, 9'd355, 0, 16'd0},
		'{HOUR_NOON, 9'd365, 0, 16'd0},
		'{17'sd51200, 9'd100, 0, 16'd0},
		'{17'sd12288, 9'd172, 0, 16'd0},
		'{17'sd36864, 9'd172, 0, 16'd0},
		'{17'sd65535, 9'd50, 0, 16'd0},
		'{-17'sd65536, 9'd50, 0, 16'd0},
		'{HOUR_NOON, 9'd0, 0, 16'd0},
		'{HOUR_NOON, 9'd511, 0, 16'd0},
		'{17'sd20000, 9'd366, 0, 16'd0},
		'{17'sd30000, 9'd256, 0, 16'd0}
	};

	initial begin
		lat_reg = '0;
		slope_reg = '0;
		azim_reg = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) send_sample(rows[i].hour, rows[i].day, rows[i].known, rows[i].cosine);
		drain();

		// extremes of the register ranges, plus a write to the spare index
		write_reg(REG_LATITUDE, 16'd12868);
		write_reg(REG_SLOPE, 16'd25736);
		write_reg(REG_AZIMUTH, 16'd25736);
		write_reg(REG_SPARE, 16'hffff);
		random_phase(220);
		drain();

		write_reg(REG_LATITUDE, -16'sd12868);
		write_reg(REG_SLOPE, 16'd0);
		write_reg(REG_AZIMUTH, -16'sd25736);
		// receiver holds off for a long stretch so the pipeline fills
		rx_hold = LONG_HOLD;
		no_gaps = 1;
		for (int i = 0; i < 150; i++)
			send_sample(17'($urandom_range(0, 51200)), 9'($urandom_range(1, 365)), 0, '0);
		no_gaps = 0;
		random_phase(80);
		drain();

		// flat collector facing the sun straight up at the equator: saturation region
		write_reg(REG_LATITUDE, 16'd0);
		write_reg(REG_SLOPE, 16'd0);
		write_reg(REG_AZIMUTH, 16'd0);
		random_phase(150);
		drain();

		// all-ones latitude and slope data exercise the field masks; azimuth takes its largest positive value
		write_reg(REG_LATITUDE, 16'hffff);
		write_reg(REG_SLOPE, 16'hffff);
		write_reg(REG_AZIMUTH, 16'h7fff);
		random_phase(150);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_LATITUDE, 16'($urandom_range(0, 25736) - 12868));
			write_reg(REG_SLOPE, 16'($urandom_range(0, 25736)));
			write_reg(REG_AZIMUTH, (p == 0) ? 16'($urandom) :
				16'($urandom_range(0, 51472) - 25736));
			random_phase(190);
			drain();
		end

		$display("covered %0d results over directed rows, range extremes and random sites", checked);
		$display("including a long receiver hold-off and out-of-range hours, days and registers");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
`default_nettype wire
